/* rtl/itcb_pkg.sv */
package itcb_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 23;
  localparam int MUL_STEPS    = 32;
  localparam int DIV_STEPS    = 4;
  localparam int ANGLE_STEPS  = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
  localparam int CNT_W        = 6;

  localparam int ACCEL_W  = 15;
  localparam int RATE_W   = 16;
  localparam int TIME_W   = 32;
  localparam int ANGLE_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] GYRO_SCALE_RST    = 24'd146801;
  localparam logic [16:0] BLEND_WEIGHT_RST  = 17'd62915;
  localparam logic [23:0] TILT_OFFSET_X_RST = 24'hFF6B85;
  localparam logic [23:0] TILT_OFFSET_Y_RST = 24'h01947B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_SCALE    = 2'd0,
    REG_BLEND_WEIGHT  = 2'd1,
    REG_TILT_OFFSET_X = 2'd2,
    REG_TILT_OFFSET_Y = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_RND,
    ST_DIV,
    ST_ACC,
    ST_BMUL,
    ST_BSUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul_step;
    logic       sqrt_step;
    logic       rnd;
    logic       div_step;
    logic       cordic_step;
    logic       acc;
    logic       bmul;
    logic       bsum;
    logic       out_load;
    logic [4:0] shift;
  } dp_cmd_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] s);
    logic [21:0] r;
    unique case (s)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/itcb_if.sv */
interface itcb_samp_if;
  logic                                valid;
  logic                                ready;
  logic signed [itcb_pkg::ACCEL_W-1:0] accel_x;
  logic signed [itcb_pkg::ACCEL_W-1:0] accel_y;
  logic signed [itcb_pkg::ACCEL_W-1:0] accel_z;
  logic signed [itcb_pkg::RATE_W-1:0]  rate_x;
  logic signed [itcb_pkg::RATE_W-1:0]  rate_y;
  logic signed [itcb_pkg::RATE_W-1:0]  rate_z;
  logic        [itcb_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
                output ready);
endinterface

interface itcb_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [itcb_pkg::ANGLE_W-1:0] roll_deg;
  logic signed [itcb_pkg::ANGLE_W-1:0] pitch_deg;
  logic signed [itcb_pkg::ANGLE_W-1:0] yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface itcb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [itcb_pkg::CFG_IDX_W-1:0]      index;
  logic [itcb_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/itcb_ctrl.sv */
module itcb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output itcb_pkg::dp_cmd_t cmd_o
);

  itcb_pkg::state_e             state_q, state_d;
  logic [itcb_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itcb_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      itcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = itcb_pkg::ST_PREP;
        end
      end
      itcb_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = itcb_pkg::ST_MUL;
      end
      itcb_pkg::ST_MUL: begin
        cmd_o.mul_step  = 1'b1;
        cmd_o.sqrt_step = (cnt_q < itcb_pkg::CNT_W'(itcb_pkg::SQRT_STEPS));
        if (cnt_q == itcb_pkg::CNT_W'(itcb_pkg::MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = itcb_pkg::ST_RND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      itcb_pkg::ST_RND: begin
        cmd_o.rnd = 1'b1;
        cnt_d     = '0;
        state_d   = itcb_pkg::ST_DIV;
      end
      itcb_pkg::ST_DIV: begin
        cmd_o.div_step    = (cnt_q < itcb_pkg::CNT_W'(itcb_pkg::DIV_STEPS));
        cmd_o.cordic_step = (cnt_q < itcb_pkg::CNT_W'(itcb_pkg::CORDIC_STEPS));
        cmd_o.shift       = cnt_q[4:0];
        if (cnt_q == itcb_pkg::CNT_W'(itcb_pkg::ANGLE_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = itcb_pkg::ST_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      itcb_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = itcb_pkg::ST_BMUL;
      end
      itcb_pkg::ST_BMUL: begin
        cmd_o.bmul = 1'b1;
        state_d    = itcb_pkg::ST_BSUM;
      end
      itcb_pkg::ST_BSUM: begin
        cmd_o.bsum = 1'b1;
        state_d    = itcb_pkg::ST_DONE;
      end
      itcb_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = itcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itcb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/itcb_dp.sv */
module itcb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  itcb_pkg::dp_cmd_t                   cmd_i,
  input  logic                                cfg_we_i,
  input  logic [itcb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [itcb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [itcb_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [itcb_pkg::ACCEL_W-1:0] accel_y_i,
  input  logic signed [itcb_pkg::ACCEL_W-1:0] accel_z_i,
  input  logic signed [itcb_pkg::RATE_W-1:0]  rate_x_i,
  input  logic signed [itcb_pkg::RATE_W-1:0]  rate_y_i,
  input  logic signed [itcb_pkg::RATE_W-1:0]  rate_z_i,
  input  logic        [itcb_pkg::TIME_W-1:0]  time_ms_i,
  output logic signed [itcb_pkg::ANGLE_W-1:0] roll_deg_o,
  output logic signed [itcb_pkg::ANGLE_W-1:0] pitch_deg_o,
  output logic signed [itcb_pkg::ANGLE_W-1:0] yaw_deg_o
);

  localparam logic signed [63:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] DEG90   = 32'sd5898240;
  localparam logic [23:0]        RECIP_125 = 24'd8589935;

  logic [23:0]        scale_q;
  logic [16:0]        weight_q;
  logic signed [23:0] offx_q, offy_q;

  logic signed [14:0] ax_q, ay_q, az_q;
  logic signed [15:0] rate_q [3];
  logic [31:0]        dt_q, dtsh_q, last_time_q;
  logic signed [47:0] acc_q [3];
  logic [39:0]        mag_q [3];
  logic               neg_q [3];
  logic [71:0]        prod_q [3];
  logic [63:0]        dq_q [3];
  logic [6:0]         rdiv_q [3];

  logic [45:0]        rad_q [2];
  logic [27:0]        rem_q [2];
  logic [22:0]        root_q [2];
  logic signed [15:0] num_q [2];
  logic signed [27:0] cx_q [2], cy_q [2];
  logic signed [31:0] cz_q [2];
  logic signed [31:0] ang_q [2];
  logic signed [41:0] phi_q [2];
  logic [40:0]        plo_q [2];
  logic signed [49:0] pang_q [2];
  logic signed [67:0] v_q [2];

  logic signed [31:0] roll_q, pitch_q, yaw_q;

  logic signed [29:0] sqx, sqy, sqz;
  logic [29:0]        sum_r, sum_p;
  logic signed [40:0] prate [3];
  logic [39:0]        pmag [3];
  logic [27:0]        remt [2], trial [2];
  logic               sge [2];
  logic [22:0]        dvt [3];
  logic [46:0]        dpr [3];
  logic [15:0]        dqd [3];
  logic [22:0]        dml [3];
  logic signed [27:0] xs [2], ys [2];
  logic signed [31:0] atv;
  logic signed [63:0] qs [3], asum [3], anew [3];
  logic signed [31:0] base [2];
  logic [16:0]        weff, comp;
  logic signed [67:0] vsh [2];
  logic signed [31:0] vsat [2];
  logic signed [31:0] ysat;

  always_comb begin
    sqx   = 30'(ax_q) * 30'(ax_q);
    sqy   = 30'(ay_q) * 30'(ay_q);
    sqz   = 30'(az_q) * 30'(az_q);
    sum_r = unsigned'(sqx) + unsigned'(sqz);
    sum_p = unsigned'(sqy) + unsigned'(sqz);
    for (int k = 0; k < 3; k++) begin
      prate[k] = 41'(rate_q[k]) * 41'(signed'({1'b0, scale_q}));
      pmag[k]  = prate[k][40] ? 40'(-prate[k]) : 40'(prate[k]);
      dvt[k]   = {rdiv_q[k], dq_q[k][63:48]};
      dpr[k]   = 47'(dvt[k]) * 47'(RECIP_125);
      dqd[k]   = dpr[k][45:30];
      dml[k]   = 23'(dqd[k]) * 23'd125;
      qs[k]    = signed'(dq_q[k]);
      asum[k]  = 64'(acc_q[k]) + (neg_q[k] ? -qs[k] : qs[k]);
      if (asum[k] > ACC_MAX) begin
        anew[k] = ACC_MAX;
      end else if (asum[k] < ACC_MIN) begin
        anew[k] = ACC_MIN;
      end else begin
        anew[k] = asum[k];
      end
    end
    atv = signed'(32'(itcb_pkg::atan_entry(cmd_i.shift)));
    for (int t = 0; t < 2; t++) begin
      remt[t]  = {rem_q[t][25:0], rad_q[t][45:44]};
      trial[t] = {3'b000, root_q[t], 2'b01};
      sge[t]   = (remt[t] >= trial[t]);
      xs[t]    = cx_q[t] >>> cmd_i.shift;
      ys[t]    = cy_q[t] >>> cmd_i.shift;
      if (root_q[t] != '0) begin
        base[t] = cz_q[t];
      end else if (num_q[t] > 16'sd0) begin
        base[t] = DEG90;
      end else if (num_q[t] < 16'sd0) begin
        base[t] = -DEG90;
      end else begin
        base[t] = '0;
      end
      vsh[t] = v_q[t] >>> 16;
      if (vsh[t] > 68'sd2147483647) begin
        vsat[t] = 32'sh7FFF_FFFF;
      end else if (vsh[t] < -68'sd2147483648) begin
        vsat[t] = -32'sh8000_0000;
      end else begin
        vsat[t] = 32'(vsh[t]);
      end
    end
    weff = (weight_q > 17'd65536) ? 17'd65536 : weight_q;
    comp = 17'd65536 - weff;
    if (acc_q[2] > 48'sh0000_7FFF_FFFF) begin
      ysat = 32'sh7FFF_FFFF;
    end else if (acc_q[2] < -48'sh0000_8000_0000) begin
      ysat = -32'sh8000_0000;
    end else begin
      ysat = 32'(acc_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= itcb_pkg::GYRO_SCALE_RST;
      weight_q    <= itcb_pkg::BLEND_WEIGHT_RST;
      offx_q      <= signed'(itcb_pkg::TILT_OFFSET_X_RST);
      offy_q      <= signed'(itcb_pkg::TILT_OFFSET_Y_RST);
      last_time_q <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (itcb_pkg::cfg_reg_e'(cfg_idx_i))
          itcb_pkg::REG_GYRO_SCALE:    scale_q  <= cfg_data_i;
          itcb_pkg::REG_BLEND_WEIGHT:  weight_q <= cfg_data_i[16:0];
          itcb_pkg::REG_TILT_OFFSET_X: offx_q   <= signed'(cfg_data_i);
          itcb_pkg::REG_TILT_OFFSET_Y: offy_q   <= signed'(cfg_data_i);
        endcase
      end
      if (cmd_i.load) begin
        last_time_q <= time_ms_i;
      end
      if (cmd_i.acc) begin
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= 48'(anew[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q      <= accel_x_i;
      ay_q      <= accel_y_i;
      az_q      <= accel_z_i;
      rate_q[0] <= rate_x_i;
      rate_q[1] <= rate_y_i;
      rate_q[2] <= rate_z_i;
      dt_q      <= time_ms_i - last_time_q;
    end
    if (cmd_i.prep) begin
      rad_q[0] <= {sum_r, 16'h0000};
      rad_q[1] <= {sum_p, 16'h0000};
      num_q[0] <= 16'(ay_q);
      num_q[1] <= -16'(ax_q);
      dtsh_q   <= dt_q;
      for (int t = 0; t < 2; t++) begin
        rem_q[t]  <= '0;
        root_q[t] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        mag_q[k]  <= pmag[k];
        neg_q[k]  <= prate[k][40];
        prod_q[k] <= '0;
      end
    end
    if (cmd_i.mul_step) begin
      dtsh_q <= {dtsh_q[30:0], 1'b0};
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= {prod_q[k][70:0], 1'b0} + (dtsh_q[31] ? 72'(mag_q[k]) : 72'd0);
      end
    end
    if (cmd_i.sqrt_step) begin
      for (int t = 0; t < 2; t++) begin
        rad_q[t]  <= {rad_q[t][43:0], 2'b00};
        rem_q[t]  <= sge[t] ? remt[t] - trial[t] : remt[t];
        root_q[t] <= {root_q[t][21:0], sge[t]};
      end
    end
    if (cmd_i.rnd) begin
      for (int k = 0; k < 3; k++) begin
        dq_q[k]   <= 64'((prod_q[k] + 72'd128000) >> 11);
        rdiv_q[k] <= '0;
      end
      for (int t = 0; t < 2; t++) begin
        cx_q[t] <= signed'(28'(root_q[t]));
        cy_q[t] <= 28'(num_q[t]) <<< 8;
        cz_q[t] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rdiv_q[k] <= 7'(dvt[k] - dml[k]);
        dq_q[k]   <= {dq_q[k][47:0], dqd[k]};
      end
    end
    if (cmd_i.cordic_step) begin
      for (int t = 0; t < 2; t++) begin
        if (!cy_q[t][27]) begin
          cx_q[t] <= cx_q[t] + ys[t];
          cy_q[t] <= cy_q[t] - xs[t];
          cz_q[t] <= cz_q[t] + atv;
        end else begin
          cx_q[t] <= cx_q[t] - ys[t];
          cy_q[t] <= cy_q[t] + xs[t];
          cz_q[t] <= cz_q[t] - atv;
        end
      end
    end
    if (cmd_i.acc) begin
      ang_q[0] <= base[0] + 32'(offx_q);
      ang_q[1] <= base[1] + 32'(offy_q);
    end
    if (cmd_i.bmul) begin
      for (int t = 0; t < 2; t++) begin
        plo_q[t]  <= 41'(weff) * 41'(acc_q[t][23:0]);
        phi_q[t]  <= 42'(signed'({1'b0, weff})) * 42'(signed'(acc_q[t][47:24]));
        pang_q[t] <= 50'(signed'({1'b0, comp})) * 50'(ang_q[t]);
      end
    end
    if (cmd_i.bsum) begin
      for (int t = 0; t < 2; t++) begin
        v_q[t] <= (68'(phi_q[t]) <<< 24) + signed'(68'(plo_q[t])) + 68'(pang_q[t])
                  + 68'sd32768;
      end
    end
    if (cmd_i.out_load) begin
      roll_q  <= vsat[0];
      pitch_q <= vsat[1];
      yaw_q   <= ysat;
    end
  end

  assign roll_deg_o  = roll_q;
  assign pitch_deg_o = pitch_q;
  assign yaw_deg_o   = yaw_q;

endmodule

/* rtl/imu_tilt_complementary_blend_top.sv */
// Complementary-filter tilt estimator. Each accepted sample word (accel triple in milli-g,
// raw gyro triple, millisecond timestamp) yields one result word of roll, pitch and yaw in
// Q16.16 degrees. One sample is processed at a time and runs from acceptance to the result
// register through a load, a setup step, 32 steps of the bit-serial gyro rate times dt
// multiply (the 23-step square roots run alongside), a rounding step, 20 CORDIC atan2
// iterations (the 4-step divide by 125 in 16-bit digits runs alongside), and the steps of
// accumulate, blend and saturate. The serial multiply and the CORDIC iterations set the
// rate. A new sample is taken while the previous result still waits on the output.
// Configuration writes are always ready and must only be issued while the block is idle.
module imu_tilt_complementary_blend_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  itcb_samp_if.sink    samp_i,
  itcb_res_if.source   res_o,
  itcb_cfg_if.sink     cfg_i
);

  itcb_pkg::dp_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  itcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (samp_i.valid),
    .in_ready_o  (samp_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  itcb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .accel_x_i   (samp_i.accel_x),
    .accel_y_i   (samp_i.accel_y),
    .accel_z_i   (samp_i.accel_z),
    .rate_x_i    (samp_i.rate_x),
    .rate_y_i    (samp_i.rate_y),
    .rate_z_i    (samp_i.rate_z),
    .time_ms_i   (samp_i.time_ms),
    .roll_deg_o  (res_o.roll_deg),
    .pitch_deg_o (res_o.pitch_deg),
    .yaw_deg_o   (res_o.yaw_deg)
  );

endmodule

/* bench/imu_tilt_complementary_blend_top_test.sv */
module imu_tilt_complementary_blend_top_test;
  import itcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic signed [ACCEL_W-1:0] az;
    logic signed [RATE_W-1:0]  rx;
    logic signed [RATE_W-1:0]  ry;
    logic signed [RATE_W-1:0]  rz;
    logic [TIME_W-1:0]         tm;
  } sample_t;

  typedef struct {
    logic [ANGLE_W-1:0] roll;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] yaw;
  } angles_t;

  localparam longint ANG_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ANG_LO = -64'sh0000_8000_0000_0000;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam int     STALL_LIMIT = 5000;

  localparam longint ARCTAN_Q16 [0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  logic clk_i;
  logic rst_ni;

  itcb_samp_if samp ();
  itcb_res_if  res ();
  itcb_cfg_if  cfg ();

  imu_tilt_complementary_blend_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  sample_t pending_samples[$];
  angles_t expected_angles[$];

  logic [23:0] gyro_scale;
  logic [16:0] blend_weight;
  longint      offset_roll;
  longint      offset_pitch;
  logic [31:0] prev_time;
  longint      gyro_x, gyro_y, gyro_z;

  int          sender_idle_pct;
  int          receiver_stall_pct;
  logic        samp_took;
  int          errors;
  int          n_in;
  int          n_out;
  int          quiet_cycles;
  logic [31:0] stim_time;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint accel_angle(longint num, longint a, longint b);
    longint x, y, z, xs, ys;
    x = longint'(int_sqrt(longint'(a * a + b * b) << 16));
    y = num * 256;
    z = 0;
    if (x == 0) begin
      return (num > 0) ? 90 * 65536 : ((num < 0) ? -90 * 65536 : 0);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ((i < 23) ? ARCTAN_Q16[i] : 0);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ((i < 23) ? ARCTAN_Q16[i] : 0);
      end
    end
    return z;
  endfunction

  function automatic longint rate_increment(longint rate, logic [31:0] dt);
    longint p;
    bit neg;
    longint unsigned m, a, qa, ra, t;
    p = rate * longint'({40'd0, gyro_scale});
    neg = p < 0;
    m = neg ? -p : p;
    a = m * {48'd0, dt[31:16]};
    qa = a / 64'd256000;
    ra = a % 64'd256000;
    t = qa * 64'd65536 + (ra * 64'd65536 + m * {48'd0, dt[15:0]} + 64'd128000) / 64'd256000;
    return neg ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint clamp48(longint v);
    return (v > ANG_HI) ? ANG_HI : ((v < ANG_LO) ? ANG_LO : v);
  endfunction

  function automatic longint clamp32(longint v);
    return (v > S32_HI) ? S32_HI : ((v < S32_LO) ? S32_LO : v);
  endfunction

  function automatic longint mix_angle(longint gyro, longint accel);
    longint w;
    w = (blend_weight > 17'd65536) ? 65536 : longint'({47'd0, blend_weight});
    return clamp32((w * gyro + (65536 - w) * accel + 32768) >>> 16);
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    angles_t r;
    logic [31:0] dt;
    longint acc_roll, acc_pitch;
    dt = s.tm - prev_time;
    acc_roll = accel_angle(longint'(s.ay), longint'(s.ax), longint'(s.az)) + offset_roll;
    acc_pitch = accel_angle(-longint'(s.ax), longint'(s.ay), longint'(s.az)) + offset_pitch;
    prev_time = s.tm;
    gyro_x = clamp48(gyro_x + rate_increment(longint'(s.rx), dt));
    gyro_y = clamp48(gyro_y + rate_increment(longint'(s.ry), dt));
    gyro_z = clamp48(gyro_z + rate_increment(longint'(s.rz), dt));
    r.roll = 32'(mix_angle(gyro_x, acc_roll));
    r.pitch = 32'(mix_angle(gyro_y, acc_pitch));
    r.yaw = 32'(clamp32(gyro_z));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale <= GYRO_SCALE_RST;
      blend_weight <= BLEND_WEIGHT_RST;
      offset_roll <= longint'($signed(TILT_OFFSET_X_RST));
      offset_pitch <= longint'($signed(TILT_OFFSET_Y_RST));
      prev_time <= '0;
      gyro_x <= 0;
      gyro_y <= 0;
      gyro_z <= 0;
      samp_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      samp_took <= samp.valid && samp.ready;
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.index))
          REG_GYRO_SCALE:    gyro_scale <= cfg.data;
          REG_BLEND_WEIGHT:  blend_weight <= cfg.data[16:0];
          REG_TILT_OFFSET_X: offset_roll <= longint'($signed(cfg.data));
          REG_TILT_OFFSET_Y: offset_pitch <= longint'($signed(cfg.data));
          default: ;
        endcase
      end
      if (samp.valid && samp.ready) begin
        sample_t s;
        s.ax = samp.accel_x;
        s.ay = samp.accel_y;
        s.az = samp.accel_z;
        s.rx = samp.rate_x;
        s.ry = samp.rate_y;
        s.rz = samp.rate_z;
        s.tm = samp.time_ms;
        expected_angles.push_back(predict_angles(s));
        prev_time <= s.tm;
        gyro_x <= gyro_x;
        gyro_y <= gyro_y;
        gyro_z <= gyro_z;
        n_in++;
      end
      if (res.valid && res.ready) begin
        n_out++;
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected word roll=%h pitch=%h yaw=%h", $time,
                   res.roll_deg, res.pitch_deg, res.yaw_deg);
          errors++;
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (res.roll_deg !== e.roll) begin
            $display("%0t: roll expected %h actual %h", $time, e.roll, res.roll_deg);
            errors++;
          end
          if (res.pitch_deg !== e.pitch) begin
            $display("%0t: pitch expected %h actual %h", $time, e.pitch, res.pitch_deg);
            errors++;
          end
          if (res.yaw_deg !== e.yaw) begin
            $display("%0t: yaw expected %h actual %h", $time, e.yaw, res.yaw_deg);
            errors++;
          end
        end
      end
      if ((samp.valid && samp.ready) || (res.valid && res.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[imu_tilt_complementary_blend_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      res.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!samp.valid || samp_took) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          samp.valid <= 1'b1;
          samp.accel_x <= s.ax;
          samp.accel_y <= s.ay;
          samp.accel_z <= s.az;
          samp.rate_x <= s.rx;
          samp.rate_y <= s.ry;
          samp.rate_z <= s.rz;
          samp.time_ms <= s.tm;
        end else begin
          samp.valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [23:0] v);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic set_regs(logic [23:0] sc, logic [23:0] w, logic [23:0] ox, logic [23:0] oy);
    write_reg(REG_GYRO_SCALE, sc);
    write_reg(REG_BLEND_WEIGHT, w);
    write_reg(REG_TILT_OFFSET_X, ox);
    write_reg(REG_TILT_OFFSET_Y, oy);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic push_sample(int ax, int ay, int az, int rx, int ry, int rz, logic [31:0] tm);
    sample_t s;
    s.ax = ACCEL_W'(ax);
    s.ay = ACCEL_W'(ay);
    s.az = ACCEL_W'(az);
    s.rx = RATE_W'(rx);
    s.ry = RATE_W'(ry);
    s.rz = RATE_W'(rz);
    s.tm = tm;
    pending_samples.push_back(s);
  endtask

  function automatic int rand_accel();
    int k;
    k = $urandom_range(99);
    if (k < 60) return $urandom_range(2000) - 1000;
    if (k < 85) return $urandom_range(32000) - 16000;
    if (k < 92) return 0;
    return int'($signed(ACCEL_W'($urandom)));
  endfunction

  function automatic int rand_rate();
    if ($urandom_range(99) < 70) return $urandom_range(4000) - 2000;
    return int'($signed(RATE_W'($urandom)));
  endfunction

  task automatic push_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 80) stim_time = stim_time + $urandom_range(1, 50);
      else if (k < 90) stim_time = stim_time + $urandom_range(1000);
      else if (k < 95) stim_time = stim_time + $urandom;
      else stim_time = $urandom;
      push_sample(rand_accel(), rand_accel(), rand_accel(),
                  rand_rate(), rand_rate(), rand_rate(), stim_time);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pending_samples.size() != 0 || n_in != n_out);
    repeat (120) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    stim_time = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    samp.valid = 1'b0;
    samp.accel_x = '0;
    samp.accel_y = '0;
    samp.accel_z = '0;
    samp.rate_x = '0;
    samp.rate_y = '0;
    samp.rate_z = '0;
    samp.time_ms = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_sample(0, 0, 1000, 0, 0, 0, 32'd0);
    push_sample(0, 500, 0, 100, -100, 50, 32'd10);
    push_sample(0, -500, 0, -100, 100, -50, 32'd20);
    push_sample(0, 0, 0, 0, 0, 0, 32'd30);
    push_sample(-700, 0, 0, 32767, -32768, 32767, 32'd40);
    push_sample(700, 0, 0, -32768, 32767, -32768, 32'd50);
    push_sample(16383, 16383, 16383, 32767, 32767, 32767, 32'd60);
    push_sample(-16384, -16384, -16384, -32768, -32768, -32768, 32'd70);
    push_sample(16000, -16000, 16000, 1, -1, 0, 32'd71);
    push_sample(-16000, 16000, -16000, 0, 1, -1, 32'd71);
    push_sample(1, 1, 1, 1000, 1000, 1000, 32'hFFFF_FFFF);
    push_sample(-1, -1, -1, -1000, -1000, -1000, 32'd5);
    push_sample(300, 400, 866, 20000, -20000, 30000, 32'd3);
    push_sample(-300, -400, -866, -20000, 20000, -30000, 32'h8000_0000);
    push_sample(0, 1, 0, 0, 0, 0, 32'h8000_0010);
    push_sample(1, 0, 0, 0, 0, 0, 32'h8000_0020);
    stim_time = 32'h8000_0020;
    push_random(360);
    drain();

    set_regs(24'd0, 24'd0, 24'h800000, 24'h7FFFFF);
    sender_idle_pct = 72;
    receiver_stall_pct = 0;
    push_random(380);
    drain();

    set_regs(24'hFFFFFF, 24'd65536, 24'h7FFFFF, 24'h800000);
    sender_idle_pct = 0;
    receiver_stall_pct = 72;
    push_random(380);
    drain();

    set_regs(24'($urandom_range(400000)), 24'h1FFFF, 24'($urandom), 24'($urandom));
    sender_idle_pct = 19;
    receiver_stall_pct = 19;
    push_random(380);
    drain();

    set_regs(24'($urandom), 24'($urandom_range(65536)), 24'($urandom), 24'($urandom));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    push_random(380);
    drain();

    if (expected_angles.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_angles.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[imu_tilt_complementary_blend_top] OK");
    end else begin
      $display("[imu_tilt_complementary_blend_top] ERROR");
    end
    $finish;
  end

endmodule

/* imu_tilt_complementary_blend_top.f */
rtl/itcb_pkg.sv
rtl/itcb_if.sv
rtl/itcb_ctrl.sv
rtl/itcb_dp.sv
rtl/imu_tilt_complementary_blend_top.sv
bench/imu_tilt_complementary_blend_top_test.sv
